// ----- rtl/ffrp_pkg.sv -----
`timescale 1ns / 1ps

package ffrp_pkg;

    localparam int INIT_SIDE_DEF = 64;
    localparam int MAX_SIDE_DEF  = 256;

    localparam int DIM_W      = 8;   // width_minus_one, height_minus_one, pos_x, pos_y
    localparam int LEN_W      = 9;   // true width / height, side_now
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 32;
    localparam int M_PAD_W    = M_TDATA_W - (2 * DIM_W + LEN_W);

    typedef struct packed {
        logic clr_step;
        logic load;
        logic grow;
        logic fail;
        logic y_init;
        logic y_next;
        logic rd_init;
        logic rd_step;
        logic scan_init;
        logic scan_step;
        logic hit;
        logic mask_build;
        logic mark_rd;
        logic mark_wr;
        logic mark_next;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic fits;
        logic at_max;
        logic y_last;
        logic rd_last;
        logic scan_end;
        logic scan_hit;
        logic mark_last;
        logic out_busy;
    } sts_t;

endpackage

// ----- rtl/ffrp_ram.sv -----
`timescale 1ns / 1ps

module ffrp_ram #(
    parameter int WIDTH = 256,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/ffrp_ctrl.sv -----
`timescale 1ns / 1ps

module ffrp_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output ffrp_pkg::cmd_t   cmd,
    input  ffrp_pkg::sts_t   sts
);

    typedef enum logic [10:0] {
        ST_CLEAR   = 11'b00000000001,
        ST_IDLE    = 11'b00000000010,
        ST_SIZE    = 11'b00000000100,
        ST_GROW    = 11'b00000001000,
        ST_READ    = 11'b00000010000,
        ST_RWAIT   = 11'b00000100000,
        ST_SCAN    = 11'b00001000000,
        ST_MASK    = 11'b00010000000,
        ST_MARK_RD = 11'b00100000000,
        ST_MARK_WR = 11'b01000000000,
        ST_DONE    = 11'b10000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SIZE;
                end
            end
            ST_SIZE: begin
                if (sts.fits) begin
                    cmd.y_init  = 1'b1;
                    cmd.rd_init = 1'b1;
                    state_next  = ST_READ;
                end else begin
                    state_next = ST_GROW;
                end
            end
            ST_GROW: begin
                if (sts.at_max) begin
                    cmd.fail   = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    cmd.grow   = 1'b1;
                    state_next = ST_SIZE;
                end
            end
            ST_READ: begin
                cmd.rd_step = 1'b1;
                if (sts.rd_last) begin
                    state_next = ST_RWAIT;
                end
            end
            ST_RWAIT: begin
                cmd.scan_init = 1'b1;
                state_next    = ST_SCAN;
            end
            ST_SCAN: begin
                if (sts.scan_end) begin
                    if (sts.y_last) begin
                        state_next = ST_GROW;
                    end else begin
                        cmd.y_next  = 1'b1;
                        cmd.rd_init = 1'b1;
                        state_next  = ST_READ;
                    end
                end else if (sts.scan_hit) begin
                    cmd.hit    = 1'b1;
                    state_next = ST_MASK;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_MASK: begin
                cmd.mask_build = 1'b1;
                state_next     = ST_MARK_RD;
            end
            ST_MARK_RD: begin
                cmd.mark_rd = 1'b1;
                state_next  = ST_MARK_WR;
            end
            ST_MARK_WR: begin
                cmd.mark_wr = 1'b1;
                if (sts.mark_last) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.mark_next = 1'b1;
                    state_next    = ST_MARK_RD;
                end
            end
            ST_DONE: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/ffrp_dp.sv -----
`timescale 1ns / 1ps

module ffrp_dp #(
    parameter int INIT_SIDE = ffrp_pkg::INIT_SIDE_DEF,
    parameter int MAX_SIDE  = ffrp_pkg::MAX_SIDE_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [ffrp_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ffrp_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tuser,
    input  ffrp_pkg::cmd_t                   cmd,
    output ffrp_pkg::sts_t                   sts
);

    localparam int AW         = $clog2(MAX_SIDE);
    localparam int SW         = $clog2(MAX_SIDE + 1);
    localparam int LW         = ffrp_pkg::LEN_W;
    localparam int DW         = ffrp_pkg::DIM_W;
    localparam int EW         = ((SW > LW) ? SW : LW) + 1;
    localparam int START_SIDE = (INIT_SIDE < MAX_SIDE) ? INIT_SIDE : MAX_SIDE;

    logic [SW-1:0]       side_reg,     side_next;
    logic [AW-1:0]       clr_reg,      clr_next;
    logic                rd_vld_reg,   rd_vld_next;
    logic                m_tvalid_reg, m_tvalid_next;

    logic [LW-1:0]       w_reg,        w_next;
    logic [LW-1:0]       h_reg,        h_next;
    logic [AW-1:0]       y_reg,        y_next;
    logic [DW-1:0]       k_reg,        k_next;
    logic [MAX_SIDE-1:0] acc_reg,      acc_next;
    logic [SW-1:0]       x_reg,        x_next;
    logic [LW-1:0]       run_reg,      run_next;
    logic [AW-1:0]       px_reg,       px_next;
    logic [AW-1:0]       py_reg,       py_next;
    logic                ok_reg,       ok_next;
    logic [MAX_SIDE-1:0] mask_reg,     mask_next;
    logic [DW-1:0]       m_reg,        m_next;
    logic [DW-1:0]       pos_x_reg,    pos_x_next;
    logic [DW-1:0]       pos_y_reg,    pos_y_next;
    logic [LW-1:0]       side_out_reg, side_out_next;
    logic                placed_reg,   placed_next;

    logic [EW-1:0] side_e, w_e, h_e, y_e, k_e, x_e, run_e, px_e, py_e, m_e;
    logic [EW-1:0] rd_row_e, wr_row_e, px_hit_e;
    logic [SW:0]   side_dbl;

    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [MAX_SIDE-1:0] ram_wdata, ram_rdata;

    assign side_e   = EW'(side_reg);
    assign w_e      = EW'(w_reg);
    assign h_e      = EW'(h_reg);
    assign y_e      = EW'(y_reg);
    assign k_e      = EW'(k_reg);
    assign x_e      = EW'(x_reg);
    assign run_e    = EW'(run_reg);
    assign px_e     = EW'(px_reg);
    assign py_e     = EW'(py_reg);
    assign m_e      = EW'(m_reg);
    assign rd_row_e = cmd.mark_rd ? (py_e + m_e) : (y_e + k_e);
    assign wr_row_e = py_e + m_e;
    assign px_hit_e = x_e + EW'(1) - w_e;
    assign side_dbl = {side_reg, 1'b0};

    assign sts.fits      = (w_e <= side_e) && (h_e <= side_e);
    assign sts.at_max    = side_e >= EW'(MAX_SIDE);
    assign sts.y_last    = (y_e + h_e) == side_e;
    assign sts.rd_last   = (k_e + EW'(1)) == h_e;
    assign sts.scan_end  = x_e == side_e;
    assign sts.scan_hit  = !acc_reg[0] && ((run_e + EW'(1)) == w_e);
    assign sts.mark_last = (m_e + EW'(1)) == h_e;
    assign sts.clr_last  = clr_reg == AW'(MAX_SIDE - 1);
    assign sts.out_busy  = m_tvalid_reg && !m_tready;

    assign ram_re    = cmd.rd_step | cmd.mark_rd;
    assign ram_raddr = rd_row_e[AW-1:0];
    assign ram_we    = cmd.clr_step | cmd.mark_wr;
    assign ram_waddr = cmd.clr_step ? clr_reg : wr_row_e[AW-1:0];
    assign ram_wdata = cmd.clr_step ? '0 : (ram_rdata | mask_reg);

    ffrp_ram #(
        .WIDTH (MAX_SIDE),
        .DEPTH (MAX_SIDE)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        side_next     = side_reg;
        clr_next      = clr_reg;
        rd_vld_next   = cmd.rd_step;
        m_tvalid_next = m_tvalid_reg;
        w_next        = w_reg;
        h_next        = h_reg;
        y_next        = y_reg;
        k_next        = k_reg;
        acc_next      = acc_reg;
        x_next        = x_reg;
        run_next      = run_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        ok_next       = ok_reg;
        mask_next     = mask_reg;
        m_next        = m_reg;
        pos_x_next    = pos_x_reg;
        pos_y_next    = pos_y_reg;
        side_out_next = side_out_reg;
        placed_next   = placed_reg;

        if (cmd.clr_step) begin
            clr_next = clr_reg + AW'(1);
        end
        if (cmd.load) begin
            w_next = LW'(s_tdata[DW-1:0]) + LW'(1);
            h_next = LW'(s_tdata[2*DW-1:DW]) + LW'(1);
        end
        if (cmd.grow) begin
            side_next = (side_dbl > (SW+1)'(MAX_SIDE)) ? SW'(MAX_SIDE) : side_dbl[SW-1:0];
        end
        if (cmd.y_init) begin
            y_next = '0;
        end
        if (cmd.y_next) begin
            y_next = y_reg + AW'(1);
        end
        if (cmd.rd_init) begin
            k_next   = '0;
            acc_next = '0;
        end
        if (cmd.rd_step) begin
            k_next = k_reg + DW'(1);
        end
        if (rd_vld_reg) begin
            acc_next = acc_reg | ram_rdata;
        end
        if (cmd.scan_init) begin
            x_next   = '0;
            run_next = '0;
        end
        if (cmd.scan_step) begin
            x_next   = x_reg + SW'(1);
            run_next = acc_reg[0] ? '0 : (run_reg + LW'(1));
            acc_next = acc_reg >> 1;
        end
        if (cmd.hit) begin
            px_next = px_hit_e[AW-1:0];
            py_next = y_reg;
            ok_next = 1'b1;
        end
        if (cmd.fail) begin
            px_next = '0;
            py_next = '0;
            ok_next = 1'b0;
        end
        if (cmd.mask_build) begin
            m_next = '0;
            for (int i = 0; i < MAX_SIDE; i++) begin
                mask_next[i] = (EW'(i) >= px_e) && (EW'(i) < (px_e + w_e));
            end
        end
        if (cmd.mark_next) begin
            m_next = m_reg + DW'(1);
        end
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
            pos_x_next    = DW'(px_e);
            pos_y_next    = DW'(py_e);
            side_out_next = side_e[LW-1:0];
            placed_next   = ok_reg;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg     <= SW'(START_SIDE);
            clr_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            side_reg     <= side_next;
            clr_reg      <= clr_next;
            rd_vld_reg   <= rd_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        w_reg        <= w_next;
        h_reg        <= h_next;
        y_reg        <= y_next;
        k_reg        <= k_next;
        acc_reg      <= acc_next;
        x_reg        <= x_next;
        run_reg      <= run_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        ok_reg       <= ok_next;
        mask_reg     <= mask_next;
        m_reg        <= m_next;
        pos_x_reg    <= pos_x_next;
        pos_y_reg    <= pos_y_next;
        side_out_reg <= side_out_next;
        placed_reg   <= placed_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{ffrp_pkg::M_PAD_W{1'b0}}, side_out_reg, pos_y_reg, pos_x_reg};
    assign m_tuser  = placed_reg;

    a_out_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !(m_tvalid_reg && !m_tready))
        else $error("result loaded over a stalled beat");

    a_read_in_side: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_step |-> ((y_e + k_e) < side_e))
        else $error("region read outside atlas");

    a_mark_in_side: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mark_wr |-> ((py_e + m_e) < side_e))
        else $error("mark write outside atlas");

    a_hit_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.hit |=> ((px_e + w_e) <= side_e))
        else $error("placement crosses right edge");

    a_side_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.grow |=> (side_e <= EW'(MAX_SIDE)) && (side_e > $past(side_e)))
        else $error("side growth out of range");

endmodule

// ----- rtl/first_fit_rectangle_placer_top.sv -----
`timescale 1ns / 1ps

// First-fit rectangle placer over a square occupancy bitmap.
// Slave channel: one beat per rectangle (width and height minus one, in cells).
// Master channel: one beat per rectangle with the top-left corner, the atlas
// side after the placement and a placed flag (low when nothing fits even at
// MAX_SIDE; position then reads zero and the bitmap is untouched).
// The bitmap lives in a MAX_SIDE x MAX_SIDE RAM, one row per word.
// Reset: the bitmap is cleared one row per cycle, all MAX_SIDE rows, with
// s_tready low; the side starts at min(INIT_SIDE, MAX_SIDE).
// Operation: one item at a time. For every candidate row y the h rows of the
// region are read and ORed, then columns are scanned one per cycle until a
// free run of width w or the side is reached. Marking reads and rewrites the
// h rows of the placed region; growth doubles the side up to MAX_SIDE. Region
// rows are read one at a time through the single read port of the bitmap RAM.
// Stall: the result sits in an output register; a new beat is accepted once
// it is issued, and a finished result waits for the register to drain.

module first_fit_rectangle_placer_top #(
    parameter int INIT_SIDE = ffrp_pkg::INIT_SIDE_DEF,
    parameter int MAX_SIDE  = ffrp_pkg::MAX_SIDE_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ffrp_pkg::S_TDATA_W-1:0]  s_tdata,   // width_minus_one, height_minus_one
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ffrp_pkg::M_TDATA_W-1:0]  m_tdata,   // pos_x, pos_y, side_now, zero pad
    output logic                            m_tuser    // placed
);

    ffrp_pkg::cmd_t cmd;
    ffrp_pkg::sts_t sts;

    ffrp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    ffrp_dp #(
        .INIT_SIDE (INIT_SIDE),
        .MAX_SIDE  (MAX_SIDE)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule
